### sv/dtss_pkg.sv
`timescale 1ns / 1ps

package dtss_pkg;

    localparam int NUM_TIERS    = 6;
    localparam int REG_COUNT    = 6;
    localparam int USABLE_TIERS = (NUM_TIERS > REG_COUNT) ? REG_COUNT : NUM_TIERS;
    localparam int RESET_TIER_I = (3 > USABLE_TIERS - 1) ? USABLE_TIERS - 1 : 3;

    localparam int TIER_W  = 3;
    localparam int POINT_W = 14;
    localparam int ACT_W   = 4;
    localparam int VAL_W   = 4;
    localparam int VDDD_W  = 3;
    localparam int VDDIG_W = 4;
    localparam int CKSEL_W = 2;
    localparam int DIV_W   = 4;

    typedef logic [TIER_W-1:0]  tier_t;
    typedef logic [POINT_W-1:0] point_t;
    typedef logic [VAL_W-1:0]   value_t;
    typedef logic [VDDD_W-1:0]  vddd_t;
    typedef logic [VDDIG_W-1:0] vddig_t;
    typedef logic [CKSEL_W-1:0] cksel_t;
    typedef logic [DIV_W-1:0]   div_t;

    typedef enum logic [ACT_W-1:0] {
        ACT_VDDD    = 4'd0,
        ACT_VDDIG   = 4'd1,
        ACT_CLKDIV  = 4'd2,
        ACT_CKSEL   = 4'd3,
        ACT_CPU0    = 4'd4,
        ACT_CPU1    = 4'd5,
        ACT_CPU2    = 4'd6,
        ACT_BARRIER = 4'd7,
        ACT_TICK    = 4'd8,
        ACT_STATUS  = 4'd9
    } action_t;

    localparam tier_t  RESET_TIER   = tier_t'(RESET_TIER_I);
    localparam tier_t  TIER_LIMIT   = tier_t'(USABLE_TIERS);
    localparam vddd_t  RAIL_VDDD_RST  = 3'd6;
    localparam vddig_t RAIL_VDDIG_RST = 4'd12;

    localparam point_t POINT_RESET [REG_COUNT] = '{
        14'd235, 14'd14315, 14'd13803, 14'd13292, 14'd12781, 14'd8318
    };

    typedef struct packed {
        logic    load;
        logic    init_step;
        logic    step_inc;
        logic    step_dec;
        logic    emit;
        action_t act;
        logic    commit;
    } dtss_cmd_t;

    typedef struct packed {
        logic invalid;
        logic same;
        logic up;
        logic at_target;
        logic div_zero;
        logic vddd_diff;
        logic vddig_diff;
        logic out_free;
    } dtss_sts_t;

    function automatic cksel_t pt_cksel(input point_t p);
        return p[13:12];
    endfunction

    function automatic div_t pt_div(input point_t p);
        return p[11:8];
    endfunction

    function automatic logic pt_cpu0(input point_t p);
        return p[7];
    endfunction

    function automatic vddd_t pt_vddd(input point_t p);
        return p[6:4];
    endfunction

    function automatic vddig_t pt_vddig(input point_t p);
        return p[3:0];
    endfunction

endpackage

### sv/dvfs_tier_step_sequencer_core.sv
`timescale 1ns / 1ps

// Operating-tier step sequencer. A transfer on the input carries a target tier;
// the block walks the current tier toward it one tier at a time and issues one
// write command per output transfer, then a tick-recalc command when the tier
// changed, and always a final status item with last set (error set when the
// target is not a usable tier). One request is worked at a time: input stall
// stays high from acceptance until the status item is loaded. The sequencer
// state machine visits one state per cycle while the output is not stalled;
// a rail write whose code is unchanged emits no item but its state is still
// visited. Tier point registers are written through cfg_we; the user must
// write them only while the block is idle, as the block does not enforce it.

module dvfs_tier_step_sequencer_core
    import dtss_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [13:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  target_tier,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [3:0]  action,
    output logic [3:0]  write_value,
    output logic [2:0]  step_tier,
    output logic        error,
    output logic [2:0]  now_tier,
    output logic        last
);

    dtss_cmd_t cmd;
    dtss_sts_t sts;

    dtss_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    dtss_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .target_tier (target_tier),
        .cmd         (cmd),
        .sts         (sts),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .action      (action),
        .write_value (write_value),
        .step_tier   (step_tier),
        .error       (error),
        .now_tier    (now_tier),
        .last        (last)
    );

endmodule

### sv/dtss_dp.sv
`timescale 1ns / 1ps

module dtss_dp
    import dtss_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  point_t      cfg_data,
    input  tier_t       target_tier,
    input  dtss_cmd_t   cmd,
    output dtss_sts_t   sts,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [3:0]  action,
    output logic [3:0]  write_value,
    output logic [2:0]  step_tier,
    output logic        error,
    output logic [2:0]  now_tier,
    output logic        last
);

    point_t  point_reg [REG_COUNT];
    tier_t   target_reg;
    tier_t   cur_reg;
    tier_t   step_reg;
    vddd_t   rail_vddd_reg;
    vddig_t  rail_vddig_reg;

    logic    out_valid_reg;
    logic    out_valid_next;
    action_t act_reg;
    value_t  value_reg;
    tier_t   tier_reg;
    logic    error_reg;
    tier_t   now_reg;
    logic    last_reg;

    point_t  point;
    value_t  value_next;
    tier_t   tier_next;
    logic    invalid;

    always_comb
    begin
        point = '0;
        for (int i = 0; i < REG_COUNT; i++)
        begin
            if (step_reg == tier_t'(i))
            begin
                point = point_reg[i];
            end
        end
    end

    assign invalid = (target_reg >= TIER_LIMIT);

    assign sts.invalid    = invalid;
    assign sts.same       = (target_reg == cur_reg);
    assign sts.up         = (target_reg > cur_reg);
    assign sts.at_target  = (step_reg == target_reg);
    assign sts.div_zero   = (pt_div(point) == '0);
    assign sts.vddd_diff  = (pt_vddd(point) != rail_vddd_reg);
    assign sts.vddig_diff = (pt_vddig(point) != rail_vddig_reg);
    assign sts.out_free   = !out_valid_reg || !out_stall;

    always_comb
    begin
        case (cmd.act)
            ACT_VDDD:   value_next = value_t'(pt_vddd(point));
            ACT_VDDIG:  value_next = value_t'(pt_vddig(point));
            ACT_CLKDIV: value_next = value_t'(pt_div(point));
            ACT_CKSEL:  value_next = value_t'(pt_cksel(point));
            ACT_CPU0:   value_next = value_t'(pt_cpu0(point));
            ACT_CPU1:   value_next = value_t'(1);
            ACT_CPU2:   value_next = value_t'(1);
            default:    value_next = '0;
        endcase
    end

    always_comb
    begin
        case (cmd.act)
            ACT_TICK:   tier_next = target_reg;
            ACT_STATUS: tier_next = cur_reg;
            default:    tier_next = step_reg;
        endcase
    end

    assign out_valid_next = cmd.emit || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < REG_COUNT; i++)
            begin
                point_reg[i] <= POINT_RESET[i];
            end
            cur_reg        <= RESET_TIER;
            rail_vddd_reg  <= RAIL_VDDD_RST;
            rail_vddig_reg <= RAIL_VDDIG_RST;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            for (int i = 0; i < REG_COUNT; i++)
            begin
                if (cfg_we && cfg_index == 3'(i))
                begin
                    point_reg[i] <= cfg_data;
                end
            end
            if (cmd.emit && cmd.act == ACT_VDDD)
            begin
                rail_vddd_reg <= pt_vddd(point);
            end
            if (cmd.emit && cmd.act == ACT_VDDIG)
            begin
                rail_vddig_reg <= pt_vddig(point);
            end
            if (cmd.commit)
            begin
                cur_reg <= target_reg;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            target_reg <= target_tier;
        end
        if (cmd.init_step)
        begin
            step_reg <= sts.up ? cur_reg + tier_t'(1) : cur_reg - tier_t'(1);
        end
        else if (cmd.step_inc)
        begin
            step_reg <= step_reg + tier_t'(1);
        end
        else if (cmd.step_dec)
        begin
            step_reg <= step_reg - tier_t'(1);
        end
        if (cmd.emit)
        begin
            act_reg   <= cmd.act;
            value_reg <= value_next;
            tier_reg  <= tier_next;
            error_reg <= (cmd.act == ACT_STATUS) && invalid;
            now_reg   <= (cmd.act == ACT_STATUS) ? cur_reg : '0;
            last_reg  <= (cmd.act == ACT_STATUS);
        end
    end

    assign out_valid   = out_valid_reg;
    assign action      = act_reg;
    assign write_value = value_reg;
    assign step_tier   = tier_reg;
    assign error       = error_reg;
    assign now_tier    = now_reg;
    assign last        = last_reg;

endmodule

### sv/dtss_ctrl.sv
`timescale 1ns / 1ps

module dtss_ctrl
    import dtss_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  dtss_sts_t sts,
    output dtss_cmd_t cmd
);

    typedef enum logic [20:0] {
        S_IDLE     = 21'h000001,
        S_DECIDE   = 21'h000002,
        S_UP_VDDD  = 21'h000004,
        S_UP_VDDIG = 21'h000008,
        S_UP_CPU0A = 21'h000010,
        S_UP_DIV   = 21'h000020,
        S_UP_CPU0B = 21'h000040,
        S_UP_CPU1  = 21'h000080,
        S_UP_CPU2  = 21'h000100,
        S_UP_CKSEL = 21'h000200,
        S_UP_BAR   = 21'h000400,
        S_DN_CKSEL = 21'h000800,
        S_DN_DIV   = 21'h001000,
        S_DN_CPU0  = 21'h002000,
        S_DN_CPU1  = 21'h004000,
        S_DN_CPU2  = 21'h008000,
        S_DN_BAR   = 21'h010000,
        S_DN_VDDIG = 21'h020000,
        S_DN_VDDD  = 21'h040000,
        S_TICK     = 21'h080000,
        S_STATUS   = 21'h100000
    } state_t;

    state_t  state_reg;
    state_t  state_next;
    state_t  nxt;
    action_t act;
    logic    emit_st;
    logic    cond;
    logic    leave;

    always_comb
    begin
        state_next = state_reg;
        nxt        = state_reg;
        cmd        = '0;
        cmd.act    = ACT_STATUS;
        act        = ACT_STATUS;
        in_stall   = 1'b1;
        emit_st    = 1'b1;
        cond       = 1'b1;
        leave      = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                emit_st  = 1'b0;
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                emit_st = 1'b0;
                if (sts.invalid || sts.same)
                begin
                    state_next = S_STATUS;
                end
                else
                begin
                    cmd.init_step = 1'b1;
                    state_next    = sts.up ? S_UP_VDDD : S_DN_CKSEL;
                end
            end
            S_UP_VDDD:
            begin
                act  = ACT_VDDD;
                cond = sts.vddd_diff;
                nxt  = S_UP_VDDIG;
            end
            S_UP_VDDIG:
            begin
                act  = ACT_VDDIG;
                cond = sts.vddig_diff;
                nxt  = S_UP_CPU0A;
            end
            S_UP_CPU0A:
            begin
                act  = ACT_CPU0;
                cond = sts.div_zero;
                nxt  = S_UP_DIV;
            end
            S_UP_DIV:
            begin
                act = ACT_CLKDIV;
                nxt = S_UP_CPU0B;
            end
            S_UP_CPU0B:
            begin
                act  = ACT_CPU0;
                cond = !sts.div_zero;
                nxt  = S_UP_CPU1;
            end
            S_UP_CPU1:
            begin
                act = ACT_CPU1;
                nxt = S_UP_CPU2;
            end
            S_UP_CPU2:
            begin
                act = ACT_CPU2;
                nxt = S_UP_CKSEL;
            end
            S_UP_CKSEL:
            begin
                act = ACT_CKSEL;
                nxt = S_UP_BAR;
            end
            S_UP_BAR:
            begin
                act = ACT_BARRIER;
                nxt = sts.at_target ? S_TICK : S_UP_VDDD;
            end
            S_DN_CKSEL:
            begin
                act = ACT_CKSEL;
                nxt = S_DN_DIV;
            end
            S_DN_DIV:
            begin
                act = ACT_CLKDIV;
                nxt = S_DN_CPU0;
            end
            S_DN_CPU0:
            begin
                act = ACT_CPU0;
                nxt = S_DN_CPU1;
            end
            S_DN_CPU1:
            begin
                act = ACT_CPU1;
                nxt = S_DN_CPU2;
            end
            S_DN_CPU2:
            begin
                act = ACT_CPU2;
                nxt = S_DN_BAR;
            end
            S_DN_BAR:
            begin
                act = ACT_BARRIER;
                nxt = S_DN_VDDIG;
            end
            S_DN_VDDIG:
            begin
                act  = ACT_VDDIG;
                cond = sts.vddig_diff;
                nxt  = S_DN_VDDD;
            end
            S_DN_VDDD:
            begin
                act  = ACT_VDDD;
                cond = sts.vddd_diff;
                nxt  = sts.at_target ? S_TICK : S_DN_CKSEL;
            end
            S_TICK:
            begin
                act = ACT_TICK;
                nxt = S_STATUS;
            end
            S_STATUS:
            begin
                act = ACT_STATUS;
                nxt = S_IDLE;
            end
            default:
            begin
                emit_st    = 1'b0;
                state_next = S_IDLE;
            end
        endcase

        if (emit_st)
        begin
            if (!cond)
            begin
                state_next = nxt;
                leave      = 1'b1;
            end
            else if (sts.out_free)
            begin
                cmd.emit   = 1'b1;
                cmd.act    = act;
                state_next = nxt;
                leave      = 1'b1;
            end
        end

        cmd.step_inc = leave && (state_reg == S_UP_BAR) && !sts.at_target;
        cmd.step_dec = leave && (state_reg == S_DN_VDDD) && !sts.at_target;
        cmd.commit   = cmd.emit && (state_reg == S_TICK);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

### sv/dtss_chk.sv
`timescale 1ns / 1ps

module dtss_chk
    import dtss_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic       out_valid,
    input logic       out_stall,
    input logic [3:0] action,
    input logic [3:0] write_value,
    input logic       error,
    input logic [2:0] now_tier,
    input logic       last
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(action) && $stable(write_value))
        else $error("stalled output transfer changed");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input accepted while a request is in progress");

    a_last_is_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (last == (action != ACT_STATUS)) |-> 1'b0)
        else $error("last does not match the status action");

    a_error_on_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && error |-> last && write_value == '0)
        else $error("error flag outside a status item");

    a_cmd_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last |-> now_tier == '0 && !error)
        else $error("status fields set on a command item");

endmodule

bind dvfs_tier_step_sequencer_core dtss_chk u_dtss_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .action      (action),
    .write_value (write_value),
    .error       (error),
    .now_tier    (now_tier),
    .last        (last)
);
